### design/rtac_pkg.sv
package rtac_pkg;

  // Request opcodes
  localparam logic [2:0] OP_READ  = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_FETCH = 3'd2;
  localparam logic [2:0] OP_MAP   = 3'd3;
  localparam logic [2:0] OP_UNMAP = 3'd4;

  // Rights bit positions
  localparam int RT_RD = 0;
  localparam int RT_WR = 1;
  localparam int RT_EX = 2;

  // Config register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILE_RIGHTS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILE_LENGTH = 1'd1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DENIED   = 2'd1,
    ST_NOSLOT   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAP,
    S_SCAN,
    S_DONE
  } state_t;

  // One table entry as held in the slot memory
  typedef struct packed {
    logic [31:0] base;
    logic [31:0] size;
    logic [31:0] offset;
    logic [2:0]  rights;
  } entry_t;

  // Table control from the sequencer
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic set_valid;
    logic clr_valid;
  } tbl_ctl_t;

endpackage

### design/region_table_access_checker.sv
// Region table access checker.
// Input channel (in_valid / in_stall): one request word per item: read, write,
// fetch, map or unmap. The block stalls its input while a request is in work.
// Output channel (out_valid / out_stall): one result word per request: status,
// slot and translated offset. The result sits in an output register; while
// the receiver stalls it holds, and the block may still take the next request
// and work on it up to the point where its own result must be written.
// Config channel (cfg_valid / cfg_ready, always ready): index 0 file rights,
// index 1 file length. Write only while idle.
// Map and rejected requests skip the scan; read/write/fetch/unmap scan the table:
// the slot memory has one read port, so the scan reads one slot per cycle,
// pipelined with the compare of the slot read the cycle before; a hit ends
// the scan early. The DONE step loads the result into the output register
// once that register is empty or being taken.
// Reset: all slots free, file rights and length zero, no result pending.
// No clearing pass; slot contents are only looked at behind a live bit.
module region_table_access_checker
  import rtac_pkg::*;
#(
  parameter int REGIONS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           in_op,
  input  logic [31:0]          in_address,
  input  logic [31:0]          in_length,
  input  logic                 in_whole_file,
  input  logic [31:0]          in_backing_offset,
  input  logic [2:0]           in_rights,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_status,
  output logic [3:0]           out_slot,
  output logic [32:0]          out_translated_offset,
  // config channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int IW = $clog2(REGIONS);
  localparam logic [IW-1:0] LAST_IDX = IW'(REGIONS - 1);

  state_t        state_r, state_nxt;

  // latched request
  logic [2:0]    op_r;
  logic [31:0]   addr_r;
  logic [31:0]   len_r;
  logic          whole_r;
  logic [31:0]   off_r;
  logic [2:0]    rights_r;

  // config registers
  logic [1:0]    file_rights_r;
  logic [31:0]   file_length_r;

  // scan pipeline
  logic [IW-1:0] rd_idx_r;
  logic          rd_end_r;
  logic          cmp_vld_r;
  logic [IW-1:0] cmp_idx_r;

  // pending result
  status_t       res_status_r, res_status_nxt;
  logic [IW-1:0] res_slot_r, res_slot_nxt;
  logic [31:0]   hit_base_r;
  logic [31:0]   hit_off_r;

  // output register
  logic          out_valid_r;
  status_t       out_status_r;
  logic [3:0]    out_slot_r;
  logic [32:0]   out_trans_r;

  // table interface
  tbl_ctl_t      tbl_ctl;
  logic [IW-1:0] upd_idx;
  entry_t        wr_entry;
  entry_t        rd_entry;
  logic          rd_live;
  logic          free_found;
  logic [IW-1:0] free_idx;

  logic          accept;
  logic          in_len_ok;
  logic          is_access;
  logic          is_unmap;
  logic          contain;
  logic          um_match;
  logic          hit;
  logic          scan_last;
  logic          rights_ok;
  logic          map_perm_ok;
  logic          out_load;
  logic [32:0]   trans;

  rtac_table #(
    .REGIONS (REGIONS)
  ) u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (tbl_ctl),
    .rd_idx     (rd_idx_r),
    .upd_idx    (upd_idx),
    .wr_entry   (wr_entry),
    .rd_entry   (rd_entry),
    .rd_live    (rd_live),
    .free_found (free_found),
    .free_idx   (free_idx)
  );

  assign accept    = in_valid && !in_stall;
  assign in_len_ok = (in_length == 32'd1) || (in_length == 32'd2) || (in_length == 32'd4);
  assign is_access = (op_r == OP_READ) || (op_r == OP_WRITE) || (op_r == OP_FETCH);
  assign is_unmap  = (op_r == OP_UNMAP);

  // containment without wrap: addr >= base, addr + len <= base + size
  assign contain  = (addr_r >= rd_entry.base) &&
                    (({1'b0, addr_r} + {1'b0, len_r}) <=
                     ({1'b0, rd_entry.base} + {1'b0, rd_entry.size}));
  assign um_match = (rd_entry.base == addr_r) && (whole_r || (rd_entry.size == len_r));
  assign hit      = cmp_vld_r && rd_live && (is_unmap ? um_match : contain);
  assign scan_last = cmp_vld_r && (cmp_idx_r == LAST_IDX);

  // fetch passes with read or execute
  always_comb begin
    case (op_r)
      OP_READ:  rights_ok = rd_entry.rights[RT_RD];
      OP_WRITE: rights_ok = rd_entry.rights[RT_WR];
      default:  rights_ok = rd_entry.rights[RT_RD] || rd_entry.rights[RT_EX];
    endcase
  end

  // requested read/write rights must lie within the file's rights
  assign map_perm_ok = ((rights_r[1:0] | file_rights_r) == file_rights_r);

  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op == OP_MAP) begin
            state_nxt = S_MAP;
          end else if (in_op == OP_UNMAP) begin
            state_nxt = S_SCAN;
          end else if ((in_op == OP_READ || in_op == OP_WRITE || in_op == OP_FETCH) &&
                       in_len_ok) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_MAP:  state_nxt = S_DONE;
      S_SCAN: begin
        if (hit || scan_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    tbl_ctl        = '0;
    upd_idx        = free_idx;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    wr_entry.base   = addr_r;
    wr_entry.size   = whole_r ? file_length_r : len_r;
    wr_entry.offset = off_r;
    wr_entry.rights = rights_r;
    in_stall       = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_status_nxt = ST_DENIED;
          res_slot_nxt   = '0;
        end
      end
      S_MAP: begin
        if (!map_perm_ok) begin
          res_status_nxt = ST_DENIED;
        end else if (!free_found) begin
          res_status_nxt = ST_NOSLOT;
        end else begin
          tbl_ctl.wr_en     = 1'b1;
          tbl_ctl.set_valid = 1'b1;
          res_status_nxt    = ST_OK;
          res_slot_nxt      = free_idx;
        end
      end
      S_SCAN: begin
        tbl_ctl.rd_en = !rd_end_r;
        upd_idx       = cmp_idx_r;
        if (hit) begin
          if (is_unmap) begin
            tbl_ctl.clr_valid = 1'b1;
            res_status_nxt    = ST_OK;
            res_slot_nxt      = cmp_idx_r;
          end else if (rights_ok) begin
            res_status_nxt = ST_OK;
            res_slot_nxt   = cmp_idx_r;
          end else begin
            res_status_nxt = ST_DENIED;
          end
        end else if (scan_last) begin
          res_status_nxt = is_unmap ? ST_NOTFOUND : ST_DENIED;
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cmp_vld_r    <= 1'b0;
      res_status_r <= ST_OK;
    end else begin
      state_r      <= state_nxt;
      cmp_vld_r    <= tbl_ctl.rd_en;
      res_status_r <= res_status_nxt;
    end
  end

  // request latch, scan index and hit data
  always_ff @(posedge clk) begin
    res_slot_r <= res_slot_nxt;
    cmp_idx_r  <= rd_idx_r;
    if (accept) begin
      op_r     <= in_op;
      addr_r   <= in_address;
      len_r    <= in_length;
      whole_r  <= in_whole_file;
      off_r    <= in_backing_offset;
      rights_r <= in_rights;
      rd_idx_r <= '0;
      rd_end_r <= 1'b0;
    end else if (tbl_ctl.rd_en) begin
      rd_idx_r <= rd_idx_r + 1'b1;
      rd_end_r <= (rd_idx_r == LAST_IDX);
    end
    if (state_r == S_SCAN && hit) begin
      hit_base_r <= rd_entry.base;
      hit_off_r  <= rd_entry.offset;
    end
  end

  // config writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_rights_r <= '0;
      file_length_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FILE_RIGHTS: file_rights_r <= cfg_data[1:0];
        CFG_FILE_LENGTH: file_length_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // translated offset, mod 2^33
  assign trans = (is_access && res_status_r == ST_OK) ?
                 ({1'b0, hit_off_r} + {1'b0, addr_r} - {1'b0, hit_base_r}) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= (res_status_r == ST_OK) ? 4'(res_slot_r) : 4'd0;
      out_trans_r  <= trans;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_slot              = out_slot_r;
  assign out_translated_offset = out_trans_r;

`ifndef SYNTHESIS
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_slot == 4'd0 && out_translated_offset == '0))
    else $error("failed result carries slot or offset");

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && scan_last) |=> (state_r == S_DONE))
    else $error("scan ran past last slot");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("accepted word lost");

  a_done_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && out_stall) |=> (state_r == S_DONE))
    else $error("pending result overwritten");
`endif

endmodule

### design/rtac_table.sv
module rtac_table
  import rtac_pkg::*;
#(
  parameter int REGIONS = 16,
  localparam int IW = $clog2(REGIONS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  tbl_ctl_t      ctl,
  input  logic [IW-1:0] rd_idx,
  input  logic [IW-1:0] upd_idx,
  input  entry_t        wr_entry,
  output entry_t        rd_entry,
  output logic          rd_live,
  output logic          free_found,
  output logic [IW-1:0] free_idx
);

  entry_t             mem [REGIONS];
  entry_t             rd_entry_r;
  logic               rd_live_r;
  logic [REGIONS-1:0] valid_r;

  // single-port style: write and read never overlap
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[upd_idx] <= wr_entry;
    end
    if (ctl.rd_en) begin
      rd_entry_r <= mem[rd_idx];
      rd_live_r  <= valid_r[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (ctl.set_valid) begin
        valid_r[upd_idx] <= 1'b1;
      end
      if (ctl.clr_valid) begin
        valid_r[upd_idx] <= 1'b0;
      end
    end
  end

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = REGIONS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  assign rd_entry = rd_entry_r;
  assign rd_live  = rd_live_r;

`ifndef SYNTHESIS
  a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.rd_en && ctl.wr_en))
    else $error("table read and write in the same cycle");

  a_set_takes: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.set_valid |=> valid_r[$past(upd_idx)])
    else $error("slot not live after map");

  a_clr_frees: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clr_valid |=> !valid_r[$past(upd_idx)])
    else $error("slot still live after unmap");
`endif

endmodule

### dv/tb_region_table_access_checker.sv
`timescale 1ns / 100ps

module tb_region_table_access_checker;
  import rtac_pkg::*;

  localparam int REGION_COUNT = 16;
  localparam int PHASES = 8;
  localparam int PHASE_WORDS = 235;
  // timeout in ns with a 12 ns clock, far beyond the slowest legal run
  localparam int LIMIT_NS = 12_000_000;

  // one request word as the input channel carries it
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] address;
    logic [31:0] length;
    logic        whole_file;
    logic [31:0] backing_offset;
    logic [2:0]  rights;
  } region_request_t;

  // one result word
  typedef struct packed {
    status_t     status;
    logic [3:0]  slot;
    logic [32:0] translated_offset;
  } region_outcome_t;

  // base and size of a region that was asked for, to aim later accesses at
  typedef struct packed {
    logic [31:0] base;
    logic [32:0] extent;
  } region_span_t;

  // Shadow copy of the slot table and file registers. Every accepted request
  // word is run against it right away; the outcomes wait in order.
  class region_table_tracker;
    bit          live [REGION_COUNT];
    bit [31:0]   base [REGION_COUNT];
    bit [32:0]   extent [REGION_COUNT];
    bit [31:0]   offs [REGION_COUNT];
    bit [2:0]    rts [REGION_COUNT];
    bit [1:0]    file_rights;
    bit [31:0]   file_length;
    region_outcome_t pending_outcomes[$];
    int unsigned failures;

    function new();
      foreach (live[i]) live[i] = 1'b0;
      file_rights = '0;
      file_length = '0;
      failures = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      if (idx == CFG_FILE_RIGHTS) file_rights = data[1:0];
      else if (idx == CFG_FILE_LENGTH) file_length = data;
    endfunction

    function int free_slots();
      int n;
      n = 0;
      foreach (live[i]) if (!live[i]) n++;
      return n;
    endfunction

    function int pending();
      return pending_outcomes.size();
    endfunction

    function void log_request(region_request_t r);
      region_outcome_t o;
      bit [2:0] need;
      bit [33:0] acc_end, reg_end;
      int hit;
      o.status = ST_DENIED;
      o.slot = '0;
      o.translated_offset = '0;
      hit = -1;
      case (r.op)
        OP_READ, OP_WRITE, OP_FETCH: begin
          need = '0;
          if (r.op == OP_READ) need[RT_RD] = 1'b1;
          else if (r.op == OP_WRITE) need[RT_WR] = 1'b1;
          else begin
            need[RT_RD] = 1'b1;
            need[RT_EX] = 1'b1;
          end
          if (r.length inside {32'd1, 32'd2, 32'd4}) begin
            acc_end = {2'b0, r.address} + {2'b0, r.length};
            for (int i = 0; i < REGION_COUNT; i++) begin
              reg_end = {2'b0, base[i]} + {1'b0, extent[i]};
              if (hit < 0 && live[i] && r.address >= base[i] && acc_end <= reg_end)
                hit = i;
            end
            // lowest containing region decides, even if it lacks the right
            if (hit >= 0 && (rts[hit] & need) != 0) begin
              o.status = ST_OK;
              o.slot = hit[3:0];
              o.translated_offset = {1'b0, offs[hit]} + {1'b0, r.address - base[hit]};
            end
          end
        end
        OP_MAP: begin
          // execute bit is not checked against the file
          if ((r.rights[1:0] | file_rights) == file_rights) begin
            for (int i = 0; i < REGION_COUNT; i++)
              if (hit < 0 && !live[i]) hit = i;
            if (hit < 0) begin
              o.status = ST_NOSLOT;
            end else begin
              live[hit] = 1'b1;
              base[hit] = r.address;
              extent[hit] = r.whole_file ? {1'b0, file_length} : {1'b0, r.length};
              offs[hit] = r.backing_offset;
              rts[hit] = r.rights;
              o.status = ST_OK;
              o.slot = hit[3:0];
            end
          end
        end
        OP_UNMAP: begin
          o.status = ST_NOTFOUND;
          for (int i = 0; i < REGION_COUNT; i++)
            if (hit < 0 && live[i] && base[i] == r.address &&
                (r.whole_file || extent[i] == {1'b0, r.length})) hit = i;
          if (hit >= 0) begin
            live[hit] = 1'b0;
            o.status = ST_OK;
            o.slot = hit[3:0];
          end
        end
        default: ;  // undefined op: denied, table untouched
      endcase
      pending_outcomes.push_back(o);
    endfunction

    function void check_result(logic [1:0] st, logic [3:0] sl, logic [32:0] tr);
      region_outcome_t o;
      if (pending_outcomes.size() == 0) begin
        $display("%0t: result word with nothing outstanding: status %0d slot %0d offset %0h",
                 $time, st, sl, tr);
        failures++;
        return;
      end
      o = pending_outcomes.pop_front();
      if (st !== o.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d", $time, o.status, st);
        failures++;
      end
      if (sl !== o.slot) begin
        $display("%0t: slot mismatch: expected %0d actual %0d", $time, o.slot, sl);
        failures++;
      end
      if (tr !== o.translated_offset) begin
        $display("%0t: translated_offset mismatch: expected %0h actual %0h",
                 $time, o.translated_offset, tr);
        failures++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [2:0]           in_op;
  logic [31:0]          in_address;
  logic [31:0]          in_length;
  logic                 in_whole_file;
  logic [31:0]          in_backing_offset;
  logic [2:0]           in_rights;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           out_status;
  logic [3:0]           out_slot;
  logic [32:0]          out_translated_offset;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  region_table_access_checker #(.REGIONS(REGION_COUNT)) uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_op                 (in_op),
    .in_address            (in_address),
    .in_length             (in_length),
    .in_whole_file         (in_whole_file),
    .in_backing_offset     (in_backing_offset),
    .in_rights             (in_rights),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_status            (out_status),
    .out_slot              (out_slot),
    .out_translated_offset (out_translated_offset),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  region_table_tracker tracker = new();

  // regions recently asked for; accesses and unmaps are aimed at these so
  // most of the random traffic actually hits live slots
  region_span_t region_history[$];

  // idle percentages for the current phase, and a long receiver hold-off
  // requested by the sequencer and counted down by the receiver process
  int unsigned sender_pct = 0;
  int unsigned receiver_pct = 0;
  int unsigned hold_left = 0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #(LIMIT_NS);
    $display("tb_region_table_access_checker NOT OK");
    $finish;
  end

  // Receiver: one stall decision per cycle, driven at the falling edge.
  initial begin
    bit stall_now;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        // long hold-off: the block fills up and has to stall its input
        stall_now = 1'b1;
        hold_left--;
      end else begin
        stall_now = (receiver_pct != 0) && ($urandom_range(99) < receiver_pct);
      end
      out_stall <= stall_now;
    end
  end

  // Result monitor: a word moves at a rising edge with valid high and no stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_result(out_status, out_slot, out_translated_offset);
  end

  function automatic region_request_t make_req(logic [2:0] op, logic [31:0] addr,
                                               logic [31:0] len, logic whole,
                                               logic [31:0] offs, logic [2:0] rts);
    region_request_t r;
    r.op = op;
    r.address = addr;
    r.length = len;
    r.whole_file = whole;
    r.backing_offset = offs;
    r.rights = rts;
    return r;
  endfunction

  function automatic void remember_region(logic [31:0] b, logic [32:0] e);
    region_span_t s;
    s.base = b;
    s.extent = e;
    region_history.push_back(s);
    if (region_history.size() > 24) void'(region_history.pop_front());
  endfunction

  // Random request word. Mostly well-formed traffic against recent regions,
  // with a tail of out-of-range lengths, stray addresses and undefined ops.
  function automatic region_request_t gen_request();
    region_request_t r;
    region_span_t s;
    int unsigned pick, span;
    s = '0;
    if (region_history.size() > 0)
      s = region_history[$urandom_range(region_history.size() - 1)];
    span = (s.extent > 33'd300) ? 300 : int'(s.extent);
    pick = $urandom_range(99);
    r.backing_offset = $urandom;
    r.rights = 3'($urandom_range(7));
    r.whole_file = ($urandom_range(99) < 15);
    if (pick < 28) begin
      r.op = OP_MAP;
      if ($urandom_range(99) < 10) r.address = $urandom;
      else r.address = {4'($urandom_range(15)), 16'h0, 12'($urandom_range(4095))};
      case ($urandom_range(9))
        0: r.length = '0;
        1: r.length = $urandom;
        default: r.length = $urandom_range(1, 256);
      endcase
      // keep most maps within the file rights so the table gets used
      if ($urandom_range(99) < 75) r.rights[1:0] = r.rights[1:0] & tracker.file_rights;
      remember_region(r.address, r.whole_file ? {1'b0, tracker.file_length}
                                              : {1'b0, r.length});
    end else if (pick < 45) begin
      r.op = OP_UNMAP;
      if ($urandom_range(99) < 85) begin
        r.address = s.base;
        r.length = s.extent[31:0] + 32'($urandom_range(9) == 0);
      end else begin
        r.address = $urandom;
        r.length = $urandom_range(0, 300);
      end
    end else if (pick < 96) begin
      r.op = 3'($urandom_range(2));
      if ($urandom_range(99) < 85)
        r.address = s.base + $urandom_range(span + 4) - 32'($urandom_range(9) == 0);
      else
        r.address = $urandom;
      if ($urandom_range(99) < 85) r.length = 32'd1 << $urandom_range(2);
      else if ($urandom_range(1) == 0) r.length = $urandom_range(0, 8);
      else r.length = $urandom;
    end else begin
      r.op = 3'($urandom_range(5, 7));
      r.address = $urandom;
      r.length = $urandom;
    end
    return r;
  endfunction

  // Offer one request word, maybe after a random gap, and hold it until taken.
  // Entered and left at a falling edge.
  task automatic send_request(input region_request_t r);
    if (sender_pct != 0 && $urandom_range(99) < sender_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < sender_pct);
    end
    in_op <= r.op;
    in_address <= r.address;
    in_length <= r.length;
    in_whole_file <= r.whole_file;
    in_backing_offset <= r.backing_offset;
    in_rights <= r.rights;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.log_request(r);
    @(negedge clk);
  endtask

  // Stop offering and let every outstanding result come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (REGION_COUNT + 4) @(posedge clk);
    @(negedge clk);
  endtask

  // Both file registers, back to back with valid held high between them.
  task automatic program_file(input logic [1:0] rights, input logic [31:0] len);
    logic [31:0] val [2];
    val[0] = {30'b0, rights};
    val[1] = len;
    for (int i = 0; i < 2; i++) begin
      cfg_index <= (i == 0) ? CFG_FILE_RIGHTS : CFG_FILE_LENGTH;
      cfg_data <= val[i];
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      tracker.write_reg((i == 0) ? CFG_FILE_RIGHTS : CFG_FILE_LENGTH, val[i]);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Directed opening: rights checks, containment at the top of the address
  // space, zero-size and overlapping regions, unmap of a freed entry,
  // undefined ops, bad lengths and a full table.
  task automatic run_directed();
    int slots_open;
    // file rights still zero: execute-only map passes, a read map is refused
    send_request(make_req(OP_MAP, 32'h1000, 32'h40, 1'b0, 32'h2000, 3'b100));
    send_request(make_req(OP_MAP, 32'h3000, 32'h10, 1'b0, 32'h0, 3'b001));
    send_request(make_req(OP_FETCH, 32'h1000, 32'd4, 1'b0, 32'h0, 3'b0));
    send_request(make_req(OP_READ, 32'h1000, 32'd1, 1'b0, 32'h0, 3'b0));
    drain_results();
    program_file(2'b11, 32'h100);
    // whole-file map ignores the length field
    send_request(make_req(OP_MAP, 32'h8000, 32'hDEAD, 1'b1, 32'hFFFF_FFFF, 3'b110));
    send_request(make_req(OP_WRITE, 32'h80FF, 32'd1, 1'b0, 32'h0, 3'b0));
    send_request(make_req(OP_FETCH, 32'h80FC, 32'd4, 1'b0, 32'h0, 3'b0));
    send_request(make_req(OP_WRITE, 32'h80FE, 32'd4, 1'b0, 32'h0, 3'b0));
    send_request(make_req(OP_READ, 32'h8000, 32'd3, 1'b0, 32'h0, 3'b0));
    // region over almost all of memory; the end of the access must not wrap
    send_request(make_req(OP_MAP, 32'h0, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 3'b111));
    send_request(make_req(OP_READ, 32'hFFFF_FFFA, 32'd4, 1'b0, 32'h0, 3'b0));
    send_request(make_req(OP_READ, 32'hFFFF_FFFC, 32'd4, 1'b0, 32'h0, 3'b0));
    // zero-size region holds nothing; overlap resolves to the lowest slot
    send_request(make_req(OP_MAP, 32'h5000, 32'h0, 1'b0, 32'h1234, 3'b011));
    send_request(make_req(OP_READ, 32'h5000, 32'd1, 1'b0, 32'h0, 3'b0));
    send_request(make_req(OP_FETCH, 32'h1000, 32'd2, 1'b0, 32'h0, 3'b0));
    // unmap: wrong size, right size, then the freed entry must not match
    send_request(make_req(OP_UNMAP, 32'h1000, 32'h41, 1'b0, 32'h0, 3'b0));
    send_request(make_req(OP_UNMAP, 32'h1000, 32'h40, 1'b0, 32'h0, 3'b0));
    send_request(make_req(OP_UNMAP, 32'h1000, 32'h0, 1'b1, 32'h0, 3'b0));
    send_request(make_req(OP_READ, 32'h1000, 32'd1, 1'b0, 32'h0, 3'b0));
    send_request(make_req(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 3'b111));
    send_request(make_req(3'd7, 32'h0, 32'h0, 1'b0, 32'h0, 3'b0));
    send_request(make_req(OP_READ, 32'h10, 32'hFFFF_FFFF, 1'b0, 32'h0, 3'b0));
    send_request(make_req(OP_UNMAP, 32'h8000, 32'h0, 1'b1, 32'h0, 3'b0));
    // fill the table, one extra map finds no slot
    slots_open = tracker.free_slots();
    for (int k = 0; k <= slots_open; k++) begin
      send_request(make_req(OP_MAP, 32'h4000_0000 + 32'(k) * 32'h100, 32'h100, 1'b0,
                            32'($urandom), 3'b011));
      remember_region(32'h4000_0000 + 32'(k) * 32'h100, 33'h100);
    end
  endtask

  initial begin
    int unsigned phase_len [PHASES];
    bit [1:0]    phase_rights [PHASES];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = '0;
    in_address = '0;
    in_length = '0;
    in_whole_file = 1'b0;
    in_backing_offset = '0;
    in_rights = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    phase_rights = '{2'd3, 2'd1, 2'd3, 2'd2, 2'd0, 2'd3, 2'd3, 2'd1};
    phase_len = '{32'h100, 32'h0, 32'hFFFF_FFFF, $urandom, 32'h40,
                  $urandom_range(1, 4096), 32'h10, 32'hFFFF_FFFF};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      program_file(phase_rights[p], phase_len[p]);
      // idle mix: none, sender only, receiver only, both
      case (p % 4)
        0: begin sender_pct = 0;  receiver_pct = 0;  end
        1: begin sender_pct = 57; receiver_pct = 0;  end
        2: begin sender_pct = 0;  receiver_pct = 57; end
        default: begin sender_pct = 27; receiver_pct = 27; end
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (n == 100 && (p == 1 || p == 4)) hold_left = 400;
        if (n == 160) drain_results();
        send_request(gen_request());
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (REGION_COUNT + 8) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending() == 0)
      $display("tb_region_table_access_checker OK");
    else
      $display("tb_region_table_access_checker NOT OK");
    $finish;
  end

endmodule

### filelist.f
design/rtac_pkg.sv
design/rtac_table.sv
design/region_table_access_checker.sv
dv/tb_region_table_access_checker.sv
